/* rtl/mlp_pkg.sv */
// ----------------------------------------------------------------------------
// mlp_pkg: shared types and constants of the two-layer perceptron
// Word formats, front-to-back command, register indexes, engine states and
// the sigmoid lookup table (sigmoid(i/32) in Q0.16 for i = 0..256).
// ----------------------------------------------------------------------------
`default_nettype none

package mlp_pkg;

  // input word as seen on the in_ channel
  typedef struct packed {
    logic               operation;
    logic               weight_layer;
    logic [6:0]         weight_row;
    logic [5:0]         weight_col;
    logic signed [15:0] weight_value;
    logic signed [15:0] feature_value;
    logic               feature_last;
  } in_word_t;

  // result word as seen on the out_ channel
  typedef struct packed {
    logic [5:0]         label_index;
    logic signed [15:0] label_activation;
    logic [15:0]        label_score;
    logic               label_predicted;
    logic               result_last;
  } out_word_t;

  // command kinds after classification
  typedef enum logic {
    CMD_WEIGHT  = 1'b0,
    CMD_FEATURE = 1'b1
  } cmd_kind_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic               wr_ok;
    logic               layer;
    logic [6:0]         row;
    logic [5:0]         col;
    logic signed [15:0] data;
    logic               last;
  } cmd_t;

  // register map, one 32-bit word per register
  typedef enum logic [1:0] {
    REG_INPUTS = 2'd0,
    REG_HIDDEN = 2'd1,
    REG_LABELS = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_t;

  localparam int SIZE_W = 7;
  localparam int GAIN_W = 13;

  typedef struct packed {
    logic [SIZE_W-1:0] inputs;
    logic [SIZE_W-1:0] hidden;
    logic [SIZE_W-1:0] labels;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  localparam logic [SIZE_W-1:0] RST_SIZE = 7'd64;
  localparam logic [GAIN_W-1:0] RST_GAIN = 13'd0;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // engine sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_H_RD,
    ST_H_MUL,
    ST_H_ACC,
    ST_T_RD,
    ST_T_LUT,
    ST_T_MUL,
    ST_T_WB,
    ST_O_BRD,
    ST_O_BIAS,
    ST_O_RD,
    ST_O_MUL,
    ST_O_ACC,
    ST_S_LUT,
    ST_S_MUL,
    ST_EMIT
  } eng_state_t;

  // sigmoid table
  localparam int          TAB_LAST = 256;
  localparam logic [63:0] EXP_STEP = 64'd4162825044;

  typedef logic [TAB_LAST:0][16:0] sig_tab_t;

  // shift-and-subtract quotient, only evaluated while the table is built
  function automatic logic [63:0] long_quot(input logic [63:0] num,
                                            input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem  = rem - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-i/32) by repeated rounded Q0.32 steps, entry = round(2^48 / (2^32 + e))
  function automatic sig_tab_t build_sig_table();
    logic [63:0] e;
    logic [63:0] den;
    sig_tab_t    t;
    e = 64'd1 << 32;
    for (int i = 0; i <= TAB_LAST; i++) begin
      den  = (64'd1 << 32) + e;
      t[i] = 17'(long_quot((64'd1 << 48) + (den >> 1), den));
      e    = (e * EXP_STEP + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

/* rtl/mlp_front.sv */
// ----------------------------------------------------------------------------
// mlp_front: input acceptance, classification and command queue
// Decodes each input word into a weight write or a feature command, checks
// the weight position against the store bounds and queues the command.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_front
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS = 64,
  parameter int MAX_HIDDEN = 64,
  parameter int MAX_LABELS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_pop
);

  cmd_t             cls;
  cmd_t             q_mem [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r;
  logic [QPW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   cnt_r;
  logic             push;

  // classify the incoming word
  always_comb begin
    cls.kind  = in_word.operation ? CMD_FEATURE : CMD_WEIGHT;
    cls.layer = in_word.weight_layer;
    cls.row   = in_word.weight_row;
    cls.col   = in_word.weight_col;
    cls.data  = in_word.operation ? in_word.feature_value : in_word.weight_value;
    cls.last  = in_word.feature_last;
    if (in_word.weight_layer) begin
      cls.wr_ok = (int'(in_word.weight_row) <= MAX_HIDDEN) &&
                  (int'(in_word.weight_col) < MAX_LABELS);
    end else begin
      cls.wr_ok = (int'(in_word.weight_row) <= MAX_INPUTS) &&
                  (int'(in_word.weight_col) < MAX_HIDDEN);
    end
  end

  assign in_stall  = (cnt_r == QCW'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= QPW'(wr_ptr_r + 1'b1);
      end
      if (cmd_pop) begin
        rd_ptr_r <= QPW'(rd_ptr_r + 1'b1);
      end
      if (push && !cmd_pop) begin
        cnt_r <= QCW'(cnt_r + 1'b1);
      end else if (!push && cmd_pop) begin
        cnt_r <= QCW'(cnt_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mlp_core.sv */
// ----------------------------------------------------------------------------
// mlp_core: inference engine
// Weight store, hidden accumulator memory, one shared multiply-accumulate,
// the tanh / sigmoid interpolation unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_core
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS = 64,
  parameter int MAX_HIDDEN = 64,
  parameter int MAX_LABELS = 64,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  cmd_valid,
  input  wire cmd_t  cmd,
  output logic       cmd_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_word_t  out_word
);

  localparam int PW          = $clog2(MAX_INPUTS + 1);
  localparam int HW          = $clog2(MAX_HIDDEN + 1);
  localparam int HIW         = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int LW          = $clog2(MAX_LABELS + 1);
  localparam int LAYER1_BASE = (MAX_INPUTS + 1) * MAX_HIDDEN;
  localparam int STORE_DEPTH = LAYER1_BASE + (MAX_HIDDEN + 1) * MAX_LABELS;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int SH          = FRAC_BITS - 5;
  localparam int SH2         = 16 - FRAC_BITS;
  localparam int HALF_SH     = 1 << (SH - 1);
  localparam int HALF2       = (SH2 == 0) ? 0 : (1 << (SH2 - 1));
  localparam int HALF_F      = 1 << (FRAC_BITS - 1);
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int LINW        = FRAC_BITS + 1;
  localparam int LPW         = LINW + 17;
  localparam int STW         = 17 + SH;

  // saturation and rounding helpers
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] rnd(input logic signed [31:0] p);
    logic signed [39:0] t;
    t = 40'(p) + 40'(HALF_F);
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic [AW-1:0] w0_addr(input int row, input int col);
    return AW'(row * MAX_HIDDEN + col);
  endfunction

  function automatic logic [AW-1:0] w1_addr(input int row, input int col);
    return AW'(LAYER1_BASE + row * MAX_LABELS + col);
  endfunction

  eng_state_t          state_r, state_nxt;
  logic [PW-1:0]       pos_r;
  logic [HW-1:0]       j_r;
  logic [HW-1:0]       i_r;
  logic [LW-1:0]       lbl_r;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic signed [15:0]  x_r;
  logic                last_r;
  logic signed [31:0]  prod_r;
  logic signed [31:0]  base_r;
  logic signed [31:0]  y_r;
  logic signed [15:0]  a_r;
  logic                neg_r;
  logic [16:0]         lo_r;
  logic [16:0]         diff_r;
  logic [SH-1:0]       fr_r;
  logic [STW-1:0]      step_r;
  logic signed [LPW-1:0] linp_r;

  logic [PW-1:0]       p_eff;
  logic [HW-1:0]       d_eff;
  logic [LW-1:0]       k_eff;
  logic [LINW-1:0]     lin_eff;

  logic [15:0]         wmem [STORE_DEPTH];
  logic [31:0]         hmem [MAX_HIDDEN];
  logic [15:0]         wa_q;
  logic [15:0]         wb_q;
  logic signed [31:0]  acc_q;

  logic                w_we;
  logic [AW-1:0]       w_waddr;
  logic [AW-1:0]       ra_addr;
  logic [AW-1:0]       rb_addr;
  logic                h_we;
  logic [HIW-1:0]      h_waddr;
  logic [HIW-1:0]      h_raddr;
  logic [31:0]         h_wdata;
  logic                out_load;

  logic                j_last;
  logic                i_last;
  logic                lbl_last;
  logic signed [31:0]  h_sum;
  logic signed [31:0]  y_sum;

  logic signed [31:0]  lut_src;
  logic signed [15:0]  lut_a;
  logic [15:0]         lut_mag;
  logic [16:0]         lut_m;
  logic [16:0]         lut_idx;
  logic [7:0]          lut_ti;
  logic [16:0]         lut_lo;
  logic [16:0]         lut_diff;

  logic [STW:0]        step_sum;
  logic [16:0]         s_val;
  logic [16:0]         t_raw;
  logic [16:0]         t_rnd;
  logic signed [39:0]  tmag;
  logic signed [39:0]  tanh_s;
  logic signed [39:0]  lin_rnd;
  logic signed [15:0]  h_new;
  logic [16:0]         sg;

  // effective sizes and gain
  always_comb begin
    if (cfg.inputs == '0) begin
      p_eff = PW'(1);
    end else if (int'(cfg.inputs) > MAX_INPUTS) begin
      p_eff = PW'(MAX_INPUTS);
    end else begin
      p_eff = PW'(cfg.inputs);
    end
    if (cfg.hidden == '0) begin
      d_eff = HW'(1);
    end else if (int'(cfg.hidden) > MAX_HIDDEN) begin
      d_eff = HW'(MAX_HIDDEN);
    end else begin
      d_eff = HW'(cfg.hidden);
    end
    if (cfg.labels == '0) begin
      k_eff = LW'(1);
    end else if (int'(cfg.labels) > MAX_LABELS) begin
      k_eff = LW'(MAX_LABELS);
    end else begin
      k_eff = LW'(cfg.labels);
    end
    if (int'(cfg.gain) > ONE) begin
      lin_eff = LINW'(ONE);
    end else begin
      lin_eff = LINW'(cfg.gain);
    end
  end

  assign j_last   = (j_r == HW'(MAX_HIDDEN - 1));
  assign i_last   = (HW'(i_r + 1'b1) == d_eff);
  assign lbl_last = (LW'(lbl_r + 1'b1) == k_eff);
  assign w_waddr  = cmd.layer ? w1_addr(int'(cmd.row), int'(cmd.col))
                              : w0_addr(int'(cmd.row), int'(cmd.col));

  // weight store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= cmd.data;
    end
    wa_q <= wmem[ra_addr];
    wb_q <= wmem[rb_addr];
  end

  // hidden accumulators: one write, one registered read
  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    acc_q <= hmem[h_raddr];
  end

  // accumulate arithmetic
  assign h_sum = sat32(40'(base_r) + rnd(prod_r));
  assign y_sum = sat32(40'(y_r) + rnd(prod_r));

  // shared table lookup: 2|a| for tanh, |act| for the score
  always_comb begin
    lut_src  = (state_r == ST_T_LUT) ? acc_q : y_r;
    lut_a    = sat16(40'(lut_src));
    lut_mag  = lut_a[15] ? 16'(-lut_a) : 16'(lut_a);
    lut_m    = (state_r == ST_T_LUT) ? {lut_mag, 1'b0} : {1'b0, lut_mag};
    lut_idx  = lut_m >> SH;
    lut_ti   = lut_idx[7:0];
    if (lut_idx >= 17'(TAB_LAST)) begin
      lut_lo   = SIG_TABLE[TAB_LAST];
      lut_diff = '0;
    end else begin
      lut_lo   = SIG_TABLE[{1'b0, lut_ti}];
      lut_diff = SIG_TABLE[9'(lut_ti) + 9'd1] - SIG_TABLE[{1'b0, lut_ti}];
    end
  end

  // interpolation finish, tanh and score
  always_comb begin
    step_sum = {1'b0, step_r} + (STW + 1)'(HALF_SH);
    s_val    = lo_r + 17'(step_sum >> SH);
    t_raw    = 17'({s_val, 1'b0} - 18'd65536);
    t_rnd    = 17'((18'(t_raw) + 18'(HALF2)) >> SH2);
    tmag     = $signed({23'b0, t_rnd});
    tanh_s   = neg_r ? -tmag : tmag;
    lin_rnd  = (40'(linp_r) + 40'(HALF_F)) >>> FRAC_BITS;
    h_new    = sat16(tanh_s + lin_rnd);
    sg       = neg_r ? 17'(18'd65536 - 18'(s_val)) : s_val;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_FEATURE) begin
          if (pos_r < p_eff) begin
            state_nxt = ST_H_RD;
          end else if (cmd.last) begin
            state_nxt = ST_T_RD;
          end
        end
      end
      ST_H_RD:   state_nxt = ST_H_MUL;
      ST_H_MUL:  state_nxt = ST_H_ACC;
      ST_H_ACC: begin
        if (!j_last) begin
          state_nxt = ST_H_RD;
        end else if (last_r) begin
          state_nxt = ST_T_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_T_RD:   state_nxt = ST_T_LUT;
      ST_T_LUT:  state_nxt = ST_T_MUL;
      ST_T_MUL:  state_nxt = ST_T_WB;
      ST_T_WB:   state_nxt = j_last ? ST_O_BRD : ST_T_RD;
      ST_O_BRD:  state_nxt = ST_O_BIAS;
      ST_O_BIAS: state_nxt = ST_O_RD;
      ST_O_RD:   state_nxt = ST_O_MUL;
      ST_O_MUL:  state_nxt = ST_O_ACC;
      ST_O_ACC:  state_nxt = i_last ? ST_S_LUT : ST_O_RD;
      ST_S_LUT:  state_nxt = ST_S_MUL;
      ST_S_MUL:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = lbl_last ? ST_IDLE : ST_O_BRD;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    cmd_pop  = 1'b0;
    w_we     = 1'b0;
    ra_addr  = w0_addr(int'(pos_r), int'(j_r));
    rb_addr  = w0_addr(int'(p_eff), int'(j_r));
    h_raddr  = j_r[HIW-1:0];
    h_waddr  = j_r[HIW-1:0];
    h_we     = 1'b0;
    h_wdata  = h_sum;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        w_we    = cmd_valid && (cmd.kind == CMD_WEIGHT) && cmd.wr_ok;
      end
      ST_H_ACC: begin
        h_we = 1'b1;
      end
      ST_T_WB: begin
        h_we    = 1'b1;
        h_wdata = 32'(h_new);
      end
      ST_O_BRD: begin
        ra_addr = w1_addr(int'(d_eff), int'(lbl_r));
      end
      ST_O_RD: begin
        ra_addr = w1_addr(int'(i_r), int'(lbl_r));
        h_raddr = i_r[HIW-1:0];
      end
      ST_EMIT: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  // sequencer counters and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      j_r         <= '0;
      i_r         <= '0;
      lbl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: j_r <= '0;
        ST_H_ACC: begin
          if (j_last) begin
            j_r   <= '0;
            pos_r <= PW'(pos_r + 1'b1);
          end else begin
            j_r <= HW'(j_r + 1'b1);
          end
        end
        ST_T_WB: begin
          if (j_last) begin
            j_r   <= '0;
            lbl_r <= '0;
          end else begin
            j_r <= HW'(j_r + 1'b1);
          end
        end
        ST_O_BIAS: i_r <= '0;
        ST_O_ACC:  i_r <= HW'(i_r + 1'b1);
        ST_EMIT: begin
          if (out_load) begin
            if (lbl_last) begin
              pos_r <= '0;
            end else begin
              lbl_r <= LW'(lbl_r + 1'b1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_FEATURE) begin
          x_r    <= cmd.data;
          last_r <= cmd.last;
        end
      end
      ST_H_MUL: begin
        prod_r <= 32'(x_r * $signed(wa_q));
        base_r <= (pos_r == '0) ? 32'($signed(wb_q)) : acc_q;
      end
      ST_T_LUT, ST_S_LUT: begin
        a_r    <= lut_a;
        neg_r  <= lut_a[15];
        lo_r   <= lut_lo;
        diff_r <= lut_diff;
        fr_r   <= lut_m[SH-1:0];
      end
      ST_T_MUL, ST_S_MUL: begin
        step_r <= STW'(diff_r * fr_r);
        linp_r <= LPW'($signed({1'b0, lin_eff}) * a_r);
      end
      ST_O_BIAS: y_r <= 32'($signed(wa_q));
      ST_O_MUL:  prod_r <= 32'($signed(acc_q[15:0]) * $signed(wa_q));
      ST_O_ACC:  y_r <= y_sum;
      ST_EMIT: begin
        if (out_load) begin
          out_word_r.label_index      <= 6'(lbl_r);
          out_word_r.label_activation <= a_r;
          out_word_r.label_score      <= sg[16] ? 16'hFFFF : sg[15:0];
          out_word_r.label_predicted  <= (sg >= 17'd32768);
          out_word_r.result_last      <= lbl_last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* rtl/two_layer_mlp_forward_pass_top.sv */
// ----------------------------------------------------------------------------
// two_layer_mlp_forward_pass_top: two-layer perceptron inference
// Input words carry weight writes or feature samples. Hidden units use
// tanh plus a linear term; each record yields one word per label.
//
// Usage:
// - in_ channel: valid/stall. A word with operation 0 writes one weight of
//   either layer (row equal to the size in use is the bias row), operation 1
//   delivers the next feature of a record; feature_last closes the record.
// - out_ channel: valid/stall, one word per label in use, result_last on the
//   final label. A two-entry command queue and the result register let each
//   side stall on its own.
// - Weight write: done by the idle engine. Feature: each of the MAX_HIDDEN
//   accumulators is updated in turn by the single shared multiply-accumulate.
// - The last feature then runs tanh over all MAX_HIDDEN units, then the output
//   layer per label, before each result word is offered.
// - While out_stall is high a pending result word holds and the engine waits.
// - Reset (rst_n low, synchronous) clears the queue, the record position
//   and the registers to their defaults; the weight store keeps no reset.
// - Registers: APB, 0x0 inputs, 0x4 hidden, 0x8 labels, 0xC linear gain.
// ----------------------------------------------------------------------------
`default_nettype none

module two_layer_mlp_forward_pass_top
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS = 64,
  parameter int MAX_HIDDEN = 64,
  parameter int MAX_LABELS = 64,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     cfg_we;
  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inputs <= RST_SIZE;
      cfg_r.hidden <= RST_SIZE;
      cfg_r.labels <= RST_SIZE;
      cfg_r.gain   <= RST_GAIN;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_INPUTS: cfg_r.inputs <= pwdata[SIZE_W-1:0];
        REG_HIDDEN: cfg_r.hidden <= pwdata[SIZE_W-1:0];
        REG_LABELS: cfg_r.labels <= pwdata[SIZE_W-1:0];
        REG_GAIN:   cfg_r.gain   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_INPUTS: prdata = 32'(cfg_r.inputs);
      REG_HIDDEN: prdata = 32'(cfg_r.hidden);
      REG_LABELS: prdata = 32'(cfg_r.labels);
      REG_GAIN:   prdata = 32'(cfg_r.gain);
      default:    prdata = '0;
    endcase
  end

  mlp_front #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_HIDDEN (MAX_HIDDEN),
    .MAX_LABELS (MAX_LABELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mlp_core #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_HIDDEN (MAX_HIDDEN),
    .MAX_LABELS (MAX_LABELS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* rtl/mlp_checker.sv */
// ----------------------------------------------------------------------------
// mlp_checker: port-level checks of the perceptron block
// Watches the result channel for handshake discipline, reset behavior and
// consistency between activation, score and predicted bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_checker
  import mlp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  // reset leaves nothing on the result channel
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // predicted bit follows the score
  a_pred_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.label_predicted == out_word.label_score[15])
    else $error("predicted bit disagrees with score");

  // predicted bit follows the sign of the activation
  a_pred_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.label_predicted != out_word.label_activation[15])
    else $error("predicted bit disagrees with activation sign");

endmodule

bind two_layer_mlp_forward_pass_top mlp_checker u_mlp_checker (.*);

`default_nettype wire

/* verif/tb_two_layer_mlp_forward_pass_top.sv */
// ----------------------------------------------------------------------------
// tb_two_layer_mlp_forward_pass_top: self-checking bench of the perceptron
// Loads weights, streams feature records through the block and compares every
// result word against a bit-exact predictor that lives in this bench. Covers
// saturation, early and late record ends, out-of-store writes, size limits
// and the linear gain, then randomized records under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_layer_mlp_forward_pass_top;
  import mlp_pkg::*;

  localparam int NIN      = 64;
  localparam int NHID     = 64;
  localparam int NLAB     = 64;
  localparam int L1_BASE  = (NIN + 1) * NHID;
  localparam int DEPTH    = L1_BASE + (NHID + 1) * NLAB;
  localparam int ONE_Q    = 4096;
  localparam int DRAIN    = 800;
  localparam int LIMIT    = 3000000;
  localparam int N_ITEMS  = 230;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  two_layer_mlp_forward_pass_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  int          wstore [DEPTH];
  bit          wset   [DEPTH];
  int          hacc   [NHID];
  int          feat_pos;
  logic [6:0]  cfg_inputs, cfg_hidden, cfg_labels;
  logic [12:0] cfg_gain;
  logic [31:0] sig_lut [0:256];

  out_word_t   expected_words [$];
  int          errors;
  int          items_sent;
  int          words_seen;
  int          records_done;
  int          cycles;
  int          burst_left;
  int          stall_run;
  int          stall_mode;

  // clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_two_layer_mlp_forward_pass_top: errors");
      $finish;
    end
  end

  // ---------------- fixed-point helpers ----------------
  function automatic longint sat_to(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 2048) >>> 12;
  endfunction

  function automatic void build_sigmoid_lut();
    logic [63:0] e, den;
    e = 64'd1 << 32;
    for (int i = 0; i <= 256; i++) begin
      den = (64'd1 << 32) + e;
      sig_lut[i] = 32'(((64'd1 << 48) + den / 2) / den);
      e = (e * 64'd4162825044 + (64'd1 << 31)) >> 32;
    end
  endfunction

  // sigmoid of a non-negative Q4.12 magnitude, interpolated
  function automatic longint sigmoid_mag(longint m);
    longint idx, fr, stp;
    idx = m >>> 7;
    if (idx >= 256) return sig_lut[256];
    fr  = m & 127;
    stp = (longint'(sig_lut[idx + 1]) - longint'(sig_lut[idx])) * fr;
    return longint'(sig_lut[idx]) + ((stp + 64) >>> 7);
  endfunction

  function automatic longint tanh_q12(longint a);
    longint m, t;
    m = (a < 0) ? -a : a;
    t = 2 * sigmoid_mag(2 * m) - 65536;
    t = (t + 8) >>> 4;
    return (a < 0) ? -t : t;
  endfunction

  function automatic int eff(int v, int mx);
    return (v == 0) ? 1 : ((v > mx) ? mx : v);
  endfunction

  function automatic int w0_addr(int r, int c);
    return r * NHID + c;
  endfunction

  function automatic int w1_addr(int r, int c);
    return L1_BASE + r * NLAB + c;
  endfunction

  // ---------------- predictor ----------------
  task automatic predict_word(in_word_t w);
    int        p, d, k, lin;
    longint    x, y, a, s;
    out_word_t r;
    if (w.operation == CMD_WEIGHT) begin
      if (w.weight_layer == 1'b0 && w.weight_row <= NIN) begin
        wstore[w0_addr(w.weight_row, w.weight_col)] = w.weight_value;
      end else if (w.weight_layer == 1'b1 && w.weight_row <= NHID) begin
        wstore[w1_addr(w.weight_row, w.weight_col)] = w.weight_value;
      end
      return;
    end
    p   = eff(cfg_inputs, NIN);
    d   = eff(cfg_hidden, NHID);
    k   = eff(cfg_labels, NLAB);
    lin = (cfg_gain > ONE_Q) ? ONE_Q : cfg_gain;
    x   = w.feature_value;
    if (feat_pos == 0) begin
      for (int j = 0; j < NHID; j++) hacc[j] = wstore[w0_addr(p, j)];
    end
    if (feat_pos < p) begin
      for (int j = 0; j < NHID; j++) begin
        hacc[j] = int'(sat_to(longint'(hacc[j]) + qmul(x, wstore[w0_addr(feat_pos, j)]), 32));
      end
      feat_pos++;
    end
    if (!w.feature_last) return;
    // hidden activation
    for (int j = 0; j < NHID; j++) begin
      a = sat_to(hacc[j], 16);
      hacc[j] = int'(sat_to(tanh_q12(a) + qmul(lin, a), 16));
    end
    // output layer
    for (int j = 0; j < k; j++) begin
      y = wstore[w1_addr(d, j)];
      for (int i = 0; i < d; i++) begin
        y = sat_to(y + qmul(hacc[i], wstore[w1_addr(i, j)]), 32);
      end
      y = sat_to(y, 16);
      s = sigmoid_mag((y < 0) ? -y : y);
      if (y < 0) s = 65536 - s;
      r.label_index      = 6'(j);
      r.label_activation = 16'(y);
      r.label_score      = (s > 65535) ? 16'hFFFF : 16'(s);
      r.label_predicted  = (s >= 32768);
      r.result_last      = (j + 1 == k);
      expected_words.push_back(r);
    end
    feat_pos = 0;
    records_done++;
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %p", out_word);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_word.label_index !== e.label_index) begin
          $error("label_index exp %0d got %0d", e.label_index, out_word.label_index);
          errors++;
        end
        if (out_word.label_activation !== e.label_activation) begin
          $error("label_activation exp %0d got %0d", e.label_activation,
                 out_word.label_activation);
          errors++;
        end
        if (out_word.label_score !== e.label_score) begin
          $error("label_score exp %0d got %0d", e.label_score, out_word.label_score);
          errors++;
        end
        if (out_word.label_predicted !== e.label_predicted) begin
          $error("label_predicted exp %0d got %0d", e.label_predicted,
                 out_word.label_predicted);
          errors++;
        end
        if (out_word.result_last !== e.result_last) begin
          $error("result_last exp %0d got %0d", e.result_last, out_word.result_last);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: runs of no stall, light, heavy or solid stall
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(5, 60);
    end
    stall_run--;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        out_stall <= 1'b1;
      end
    endcase
  end

  // ---------------- stimulus primitives ----------------
  // send one word, wait for acceptance, then maybe open a sender gap
  task automatic send_word(in_word_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_weight(bit layer, int row, int col, int val);
    in_word_t w;
    w              = '0;
    w.operation    = CMD_WEIGHT;
    w.weight_layer = layer;
    w.weight_row   = 7'(row);
    w.weight_col   = 6'(col);
    w.weight_value = 16'(val);
    w.feature_value = 16'($urandom);
    w.feature_last = $urandom_range(0, 1);
    if (layer == 1'b0 && row <= NIN) wset[w0_addr(row, col)] = 1'b1;
    if (layer == 1'b1 && row <= NHID) wset[w1_addr(row, col)] = 1'b1;
    send_word(w);
  endtask

  task automatic send_feature(int val, bit last);
    in_word_t w;
    w               = '0;
    w.operation     = CMD_FEATURE;
    w.weight_layer  = $urandom_range(0, 1);
    w.weight_row    = 7'($urandom);
    w.weight_col    = 6'($urandom);
    w.weight_value  = 16'($urandom);
    w.feature_value = 16'(val);
    w.feature_last  = last;
    send_word(w);
  endtask

  function automatic int rand_weight();
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 8192)) - 4096;
  endfunction

  function automatic int rand_feature();
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 16384)) - 8192;
  endfunction

  // write every weight the next record reads that has never been written
  task automatic fill_weights();
    int p, d, k;
    p = eff(cfg_inputs, NIN);
    d = eff(cfg_hidden, NHID);
    k = eff(cfg_labels, NLAB);
    for (int r = 0; r <= p; r++)
      for (int c = 0; c < d; c++)
        if (!wset[w0_addr(r, c)]) send_weight(1'b0, r, c, rand_weight());
    for (int r = 0; r <= d; r++)
      for (int c = 0; c < k; c++)
        if (!wset[w1_addr(r, c)]) send_weight(1'b1, r, c, rand_weight());
  endtask

  // one record of n features, with occasional weight writes mixed in
  task automatic run_record(int n, bit noisy);
    fill_weights();
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_weight($urandom_range(0, 1), $urandom_range(66, 127),
                      $urandom_range(0, 63), rand_weight());
        else
          send_weight($urandom_range(0, 1), $urandom_range(0, 64),
                      $urandom_range(0, 63), rand_weight());
      end
      send_feature(rand_feature(), i == n - 1);
    end
  endtask

  // register write, only with the block drained
  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN) @(negedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INPUTS: cfg_inputs = 7'(val);
      REG_HIDDEN: cfg_hidden = 7'(val);
      REG_LABELS: cfg_labels = 7'(val);
      default:    cfg_gain   = 13'(val);
    endcase
  endtask

  task automatic set_sizes(int ni, int nh, int nl, int g);
    write_reg(REG_INPUTS, ni);
    write_reg(REG_HIDDEN, nh);
    write_reg(REG_LABELS, nl);
    write_reg(REG_GAIN, g);
  endtask

  // ---------------- tests ----------------
  // saturation, extreme values, early and late record ends
  task automatic test_directed();
    set_sizes(2, 2, 2, 4096);
    for (int r = 0; r <= 2; r++)
      for (int c = 0; c < 2; c++) send_weight(1'b0, r, c, 32767);
    for (int r = 0; r <= 2; r++)
      for (int c = 0; c < 2; c++) send_weight(1'b1, r, c, (c == 0) ? 32767 : -32768);
    send_feature(32767, 1'b0);
    send_feature(32767, 1'b1);
    send_feature(-32768, 1'b0);
    send_feature(-32768, 1'b1);
    // early end: second feature missing
    send_feature(12345, 1'b1);
    // extra features beyond the record size are dropped
    send_feature(-700, 1'b0);
    send_feature(900, 1'b0);
    send_feature(-32768, 1'b0);
    send_feature(0, 1'b1);
    // writes outside the store and a write in the middle of a record
    send_weight(1'b0, 65, 5, 111);
    send_weight(1'b1, 127, 63, -111);
    send_feature(4096, 1'b0);
    send_weight(1'b1, 2, 1, 0);
    send_feature(-4096, 1'b1);
    run_record(2, 1'b0);
  endtask

  // size registers at and beyond their limits, gain extremes
  task automatic test_size_limits();
    set_sizes(127, 1, 1, 0);
    run_record(64, 1'b0);
    set_sizes(0, 0, 0, 8191);
    run_record(1, 1'b0);
    set_sizes(1, 0, 0, 1);
    run_record(3, 1'b0);
  endtask

  // random sizes kept small, random records with noise
  task automatic test_random();
    int n, p;
    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 2) == 0)
        set_sizes($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(0, 4096));
      p = eff(cfg_inputs, NIN);
      case ($urandom_range(0, 5))
        0:       n = $urandom_range(1, p);
        1:       n = p + $urandom_range(1, 3);
        default: n = p;
      endcase
      run_record(n, 1'b1);
    end
  endtask

  initial begin
    errors       = 0;
    items_sent   = 0;
    words_seen   = 0;
    records_done = 0;
    cycles       = 0;
    burst_left   = 0;
    stall_run    = 0;
    stall_mode   = 0;
    feat_pos     = 0;
    cfg_inputs   = 7'd64;
    cfg_hidden   = 7'd64;
    cfg_labels   = 7'd64;
    cfg_gain     = 13'd0;
    for (int i = 0; i < DEPTH; i++) begin
      wstore[i] = 0;
      wset[i]   = 1'b0;
    end
    for (int j = 0; j < NHID; j++) hacc[j] = 0;
    build_sigmoid_lut();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_size_limits();
    test_random();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d input words, %0d records, %0d result words checked",
             items_sent, records_done, words_seen);
    $display("sizes swept from zero past their limits, gain from 0 to above 1.0");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_two_layer_mlp_forward_pass_top: clean");
    end else begin
      $display("tb_two_layer_mlp_forward_pass_top: errors");
    end
    $finish;
  end

endmodule
